>>> hw/rtl/bbsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbsfd_pkg: shared types and constants
// Register indexes, result kinds, decoder modes, the configuration record
// and the record that travels from the slicer front end to the frame back end.
// ----------------------------------------------------------------------------
package bbsfd_pkg;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PREFIX_PATTERN  = 3'd0,
      CSR_PREFIX_LENGTH   = 3'd1,
      CSR_BIT_PERIOD      = 3'd2,
      CSR_SLOPE_THRESHOLD = 3'd3,
      CSR_LOCK_THRESHOLD  = 3'd4
   } csr_index_type;

   // field widths
   localparam int PREFIX_WIDTH = 32;
   localparam int PLEN_WIDTH   = 6;
   localparam int SPB_WIDTH    = 16;
   localparam int SLOPE_WIDTH  = 16;
   localparam int LOCK_WIDTH   = 15;
   localparam int KIND_WIDTH   = 2;
   localparam int BYTE_WIDTH   = 8;
   localparam int BIT_IDX_WIDTH = 3;

   // reset values of the registers
   localparam logic [PREFIX_WIDTH-1:0] PREFIX_PATTERN_RESET  = '0;
   localparam logic [PLEN_WIDTH-1:0]   PREFIX_LENGTH_RESET   = 6'd8;
   localparam logic [SPB_WIDTH-1:0]    BIT_PERIOD_RESET      = 16'd16;
   localparam logic [SLOPE_WIDTH-1:0]  SLOPE_THRESHOLD_RESET = 16'd3277;
   localparam logic [LOCK_WIDTH-1:0]   LOCK_THRESHOLD_RESET  = 15'd26214;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LENGTH = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ABORT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_ACQUIRE = 2'd0,
      MODE_HUNT    = 2'd1,
      MODE_SIZE    = 2'd2,
      MODE_COLLECT = 2'd3
   } mode_type;

   typedef struct packed {
      logic [PREFIX_WIDTH-1:0] prefix_pattern;
      logic [PLEN_WIDTH-1:0]   prefix_length;
      logic [SPB_WIDTH-1:0]    bit_period;
      logic [SLOPE_WIDTH-1:0]  slope_threshold;
      logic [LOCK_WIDTH-1:0]   lock_threshold;
   } cfg_type;

   // per-sample summary handed to the back end
   typedef struct packed {
      logic vote;    // majority of the vote window
      logic locked;  // lock level at or above threshold
      logic steep;   // slope magnitude above threshold
   } slice_type;

endpackage : bbsfd_pkg
`default_nettype wire

>>> hw/rtl/bbsfd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbsfd_if: channel interfaces
// Sample channel and result channel, each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface bbsfd_req_if
   import bbsfd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_phase;
   logic [LOCK_WIDTH-1:0]          lock_level;

   modport source (output valid, output in_phase, output lock_level, input ready);
   modport sink   (input valid, input in_phase, input lock_level, output ready);
endinterface : bbsfd_req_if

interface bbsfd_rsp_if
   import bbsfd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [KIND_WIDTH-1:0] kind;
   logic [BYTE_WIDTH-1:0] value;
   logic                  last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface : bbsfd_rsp_if
`default_nettype wire

>>> hw/rtl/bbsfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbsfd_front: sample slicer
// Slices each sample into the history, measures the slope and lock, and
// takes the majority vote in two stages: group counts, then sum and compare.
// ----------------------------------------------------------------------------
module bbsfd_front
   import bbsfd_pkg::*;
#(
   parameter int VOTE_WIDTH   = 32,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   bbsfd_req_if.sink      req_if,
   output logic           push_valid,
   output slice_type      push_item,
   input  wire logic      push_ready
);

   localparam int WIN_WIDTH   = $clog2(VOTE_WIDTH + 1);
   localparam int GROUPS      = (VOTE_WIDTH + 7) / 8;
   localparam int GROUP_WIDTH = 4;
   localparam int PAD_WIDTH   = GROUPS * 8;
   localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int MAG_WIDTH   = (DIFF_WIDTH > SLOPE_WIDTH) ? DIFF_WIDTH : SLOPE_WIDTH;

   logic [VOTE_WIDTH-1:0]   hist_ff, hist_in;
   logic [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [GROUP_WIDTH-1:0]  s1_groups_ff [GROUPS];
   logic [GROUP_WIDTH-1:0]  groups_in    [GROUPS];
   logic                    s1_locked_ff, s1_steep_ff;

   logic                    accept;
   logic                    slice_bit;
   logic [WIN_WIDTH-1:0]    win;
   logic [VOTE_WIDTH-1:0]   win_mask;
   logic [PAD_WIDTH-1:0]    padded;
   logic signed [DIFF_WIDTH-1:0] diff;
   logic [DIFF_WIDTH-1:0]   mag;
   logic                    locked, steep;
   logic [WIN_WIDTH-1:0]    ones;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || push_ready;

   // vote window: min(bit_period, VOTE_WIDTH)
   always_comb begin
      if (cfg.bit_period >= SPB_WIDTH'(VOTE_WIDTH)) begin
         win      = WIN_WIDTH'(VOTE_WIDTH);
         win_mask = '1;
      end else begin
         win      = WIN_WIDTH'(cfg.bit_period);
         win_mask = (VOTE_WIDTH'(1) << win) - VOTE_WIDTH'(1);
      end
   end

   // slice, slope and lock of the incoming sample
   always_comb begin
      slice_bit = !req_if.in_phase[SAMPLE_WIDTH-1] && (|req_if.in_phase);
      hist_in   = {hist_ff[VOTE_WIDTH-2:0], slice_bit};
      prev_in   = req_if.in_phase;
      diff      = $signed({req_if.in_phase[SAMPLE_WIDTH-1], req_if.in_phase})
                - $signed({prev_ff[SAMPLE_WIDTH-1], prev_ff});
      mag       = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
      steep     = MAG_WIDTH'(mag) > MAG_WIDTH'(cfg.slope_threshold);
      locked    = req_if.lock_level >= cfg.lock_threshold;
   end

   // first vote stage: ones per group of eight
   always_comb begin
      padded = PAD_WIDTH'(hist_in & win_mask);
      for (int g = 0; g < GROUPS; g++) begin
         groups_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            groups_in[g] = groups_in[g] + GROUP_WIDTH'(padded[g*8+b]);
         end
      end
   end

   // second vote stage: sum of groups, strict majority
   always_comb begin
      ones = '0;
      for (int g = 0; g < GROUPS; g++) begin
         ones = ones + WIN_WIDTH'(s1_groups_ff[g]);
      end
      push_item.vote   = {ones, 1'b0} > {1'b0, win};
      push_item.locked = s1_locked_ff;
      push_item.steep  = s1_steep_ff;
      push_valid       = s1_valid_ff;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // history, previous sample and stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         prev_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            hist_ff <= hist_in;
            prev_ff <= prev_in;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_groups_ff <= groups_in;
         s1_locked_ff <= locked;
         s1_steep_ff  <= steep;
      end
   end

endmodule : bbsfd_front
`default_nettype wire

>>> hw/rtl/bbsfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbsfd_queue: slice queue
// Short first-in first-out queue that decouples the slicer from the
// frame sequencer.
// ----------------------------------------------------------------------------
module bbsfd_queue
   import bbsfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire slice_type push_item,
   output logic           push_ready,
   output logic           pop_valid,
   output slice_type      pop_item,
   input  wire logic      pop_ready
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   slice_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    push, pop;

   assign push_ready = count_ff != COUNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : bbsfd_queue
`default_nettype wire

>>> hw/rtl/bbsfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbsfd_back: frame sequencer
// Bit timing, differential decoding, prefix hunt, length and data bytes,
// lock-loss abort, and the result output register.
// ----------------------------------------------------------------------------
module bbsfd_back
   import bbsfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      pop_valid,
   input  wire slice_type pop_item,
   output logic           pop_ready,
   bbsfd_rsp_if.source    rsp_if
);

   mode_type                 mode_ff, mode_in;
   logic [SPB_WIDTH-1:0]     cnt_ff, cnt_in;
   logic                     prev_bit_ff, prev_bit_in;
   logic [PREFIX_WIDTH-1:0]  bit_hist_ff, bit_hist_in;
   logic [BIT_IDX_WIDTH-1:0] bit_idx_ff, bit_idx_in;
   logic [BYTE_WIDTH-1:0]    acc_ff, acc_in;
   logic [BYTE_WIDTH-1:0]    left_ff, left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 kind_ff, kind_in;
   logic [BYTE_WIDTH-1:0]    value_ff, value_in;
   logic                     last_ff, last_in;

   logic                     take, emit;
   logic [SPB_WIDTH-1:0]     cnt_inc;
   logic                     period_done;
   logic                     diff;
   logic [PREFIX_WIDTH-1:0]  bh_next;
   logic [PLEN_WIDTH-1:0]    plen;
   logic [PREFIX_WIDTH-1:0]  pmask;
   logic                     match;
   logic [BYTE_WIDTH-1:0]    acc_next;
   logic [BYTE_WIDTH-1:0]    left_dec;

   assign take      = pop_valid && (!rsp_valid_ff || rsp_if.ready);
   assign pop_ready = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind  = kind_ff;
   assign rsp_if.value = value_ff;
   assign rsp_if.last  = last_ff;

   // bit timing, differential bit and prefix compare
   always_comb begin
      cnt_inc     = cnt_ff + 1'b1;
      period_done = !(cnt_inc < cfg.bit_period);
      diff        = pop_item.vote ^ prev_bit_ff;
      bh_next     = {bit_hist_ff[PREFIX_WIDTH-2:0], diff};
      plen        = (cfg.prefix_length > PLEN_WIDTH'(PREFIX_WIDTH)) ?
                    PLEN_WIDTH'(PREFIX_WIDTH) : cfg.prefix_length;
      pmask       = (plen >= PLEN_WIDTH'(PREFIX_WIDTH)) ? '1 :
                    (PREFIX_WIDTH'(1) << plen) - PREFIX_WIDTH'(1);
      match       = ((bh_next ^ cfg.prefix_pattern) & pmask) == '0;
      acc_next    = acc_ff | (BYTE_WIDTH'(diff) << bit_idx_ff);
      left_dec    = left_ff - 1'b1;
   end

   // mode sequencer
   always_comb begin
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      prev_bit_in = prev_bit_ff;
      bit_hist_in = bit_hist_ff;
      bit_idx_in  = bit_idx_ff;
      acc_in      = acc_ff;
      left_in     = left_ff;
      emit        = 1'b0;
      kind_in     = KIND_ABORT;
      value_in    = '0;
      last_in     = 1'b0;

      if (take) begin
         if (!pop_item.locked && mode_ff != MODE_ACQUIRE) begin
            // lock lost mid-frame
            mode_in = MODE_ACQUIRE;
            emit    = 1'b1;
            kind_in = KIND_ABORT;
            last_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_ACQUIRE: begin
                  if (pop_item.locked && pop_item.steep) begin
                     mode_in     = MODE_HUNT;
                     cnt_in      = '0;
                     prev_bit_in = 1'b0;
                     bit_hist_in = '0;
                  end
               end
               MODE_HUNT: begin
                  if (!period_done) begin
                     cnt_in = cnt_inc;
                  end else begin
                     cnt_in      = '0;
                     prev_bit_in = pop_item.vote;
                     bit_hist_in = bh_next;
                     if (match) begin
                        bit_idx_in = '0;
                        acc_in     = '0;
                        mode_in    = MODE_SIZE;
                     end
                  end
               end
               MODE_SIZE, MODE_COLLECT: begin
                  if (!period_done) begin
                     cnt_in = cnt_inc;
                  end else begin
                     cnt_in      = '0;
                     prev_bit_in = pop_item.vote;
                     if (bit_idx_ff != '1) begin
                        bit_idx_in = bit_idx_ff + 1'b1;
                        acc_in     = acc_next;
                     end else begin
                        // byte complete
                        bit_idx_in = '0;
                        acc_in     = '0;
                        emit       = 1'b1;
                        value_in   = acc_next;
                        if (mode_ff == MODE_SIZE) begin
                           kind_in = KIND_LENGTH;
                           left_in = acc_next;
                           last_in = acc_next == '0;
                           mode_in = (acc_next == '0) ? MODE_ACQUIRE : MODE_COLLECT;
                        end else begin
                           kind_in = KIND_DATA;
                           left_in = left_dec;
                           last_in = left_dec == '0;
                           if (left_dec == '0) begin
                              mode_in = MODE_ACQUIRE;
                           end
                        end
                     end
                  end
               end
               default: begin
                  mode_in = MODE_ACQUIRE;
               end
            endcase
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ACQUIRE;
         cnt_ff       <= '0;
         prev_bit_ff  <= 1'b0;
         bit_hist_ff  <= '0;
         bit_idx_ff   <= '0;
         acc_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         prev_bit_ff  <= prev_bit_in;
         bit_hist_ff  <= bit_hist_in;
         bit_idx_ff   <= bit_idx_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

endmodule : bbsfd_back
`default_nettype wire

>>> hw/rtl/bpsk_bit_sync_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_bit_sync_frame_decoder: DBPSK bit slicer and frame decoder
// Slices demodulated samples, recovers differential bits by majority vote,
// hunts for the sync prefix and returns the length byte and data bytes.
//
// Usage:
//  - req_if carries one sample item per transfer: in_phase (signed) and
//    lock_level. rsp_if returns length bytes, data bytes and abort items;
//    last marks the final item of a frame.
//  - csr_we/csr_index/csr_wdata write the five registers; write them only
//    while the block is idle. Unknown indexes are ignored.
//  - Throughput is one sample per cycle while req_if.ready stays high.
//    A sample loads the slicer/vote group stage on the accepting edge,
//    then passes through the queue, and the sequencer then loads the
//    result register that drives rsp_if.valid.
//  - A two-entry queue sits between slicer and sequencer; the sequencer
//    stops only while the result register is full and rsp_if.ready is low,
//    and req_if.ready drops once the queue and the vote stage are full.
//  - Reset (synchronous) restores register defaults, clears the histories
//    and returns the sequencer to acquisition; there is no clearing pass.
// ----------------------------------------------------------------------------
module bpsk_bit_sync_frame_decoder
   import bbsfd_pkg::*;
#(
   parameter int VOTE_WIDTH   = 32,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bbsfd_req_if.sink                       req_if,
   bbsfd_rsp_if.source                     rsp_if,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   slice_type push_item;
   logic      pop_valid, pop_ready;
   slice_type pop_item;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PREFIX_PATTERN:  cfg_in.prefix_pattern  = csr_wdata[PREFIX_WIDTH-1:0];
            CSR_PREFIX_LENGTH:   cfg_in.prefix_length   = csr_wdata[PLEN_WIDTH-1:0];
            CSR_BIT_PERIOD:      cfg_in.bit_period      = csr_wdata[SPB_WIDTH-1:0];
            CSR_SLOPE_THRESHOLD: cfg_in.slope_threshold = csr_wdata[SLOPE_WIDTH-1:0];
            CSR_LOCK_THRESHOLD:  cfg_in.lock_threshold  = csr_wdata[LOCK_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_pattern  <= PREFIX_PATTERN_RESET;
         cfg_ff.prefix_length   <= PREFIX_LENGTH_RESET;
         cfg_ff.bit_period      <= BIT_PERIOD_RESET;
         cfg_ff.slope_threshold <= SLOPE_THRESHOLD_RESET;
         cfg_ff.lock_threshold  <= LOCK_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bbsfd_front #(
      .VOTE_WIDTH   (VOTE_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   bbsfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   bbsfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule : bpsk_bit_sync_frame_decoder
`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the DBPSK bit slicer and frame decoder
// Feeds sample items through the request channel and checks every length,
// data and abort item on the result channel against an in-bench decoder
// model. It runs a short directed sequence, then random frames under several
// register settings, with random idling on both sides, a long result
// back-pressure stretch and a stretch without idling.
// ----------------------------------------------------------------------------
module tb_top;
   import bbsfd_pkg::*;

   localparam int VOTE_WIDTH   = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDLE_PCT     = 9;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_TIME = 4_000_000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] in_phase;
      logic [LOCK_WIDTH-1:0]          lock_level;
   } sample_item_type;

   typedef struct {
      kind_type              kind;
      logic [BYTE_WIDTH-1:0] value;
      logic                  last;
   } decoded_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   bbsfd_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_if ();
   bbsfd_rsp_if rsp_if ();

   bpsk_bit_sync_frame_decoder #(
      .VOTE_WIDTH(VOTE_WIDTH),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench state
   sample_item_type  sample_queue[$];
   decoded_item_type decoded_queue[$];
   int issued_count   = 0;
   int accepted_count = 0;
   int error_count    = 0;
   logic quiet    = 1'b0;
   logic hold_arm = 1'b0;
   logic rsp_hold = 1'b0;

   // decoder model: registers and state
   cfg_type                        cfg;
   logic [31:0]                    slice_hist;
   logic signed [SAMPLE_WIDTH-1:0] prev_sample;
   mode_type                       dec_mode;
   logic [SPB_WIDTH-1:0]           sample_cnt;
   logic                           prev_level;
   logic [31:0]                    bit_hist;
   logic [BIT_IDX_WIDTH-1:0]       bit_idx;
   logic [BYTE_WIDTH-1:0]          byte_acc;
   logic [BYTE_WIDTH-1:0]          bytes_left;

   // stimulus generator state
   int   gen_last  = 0;
   logic gen_level = 1'b0;

   function automatic void push_decoded(kind_type kind, logic [7:0] value, logic last);
      decoded_item_type item;
      item.kind  = kind;
      item.value = value;
      item.last  = last;
      decoded_queue.push_back(item);
   endfunction

   // majority over the newest min(bit_period, 32) slices
   function automatic logic vote_level();
      int win, ones, n;
      win  = (cfg.bit_period < VOTE_WIDTH) ? int'(cfg.bit_period) : VOTE_WIDTH;
      ones = 0;
      for (n = 0; n < win; n++) ones += slice_hist[n];
      return (2 * ones > win);
   endfunction

   // one bit decision per full period; diff is the differential bit
   function automatic logic take_decision(output logic diff);
      logic level;
      sample_cnt = sample_cnt + 16'd1;
      if (sample_cnt < cfg.bit_period) return 1'b0;
      level      = vote_level();
      diff       = level ^ prev_level;
      prev_level = level;
      sample_cnt = '0;
      return 1'b1;
   endfunction

   // advance the decoder by one accepted sample item
   function automatic void decode_sample(logic signed [SAMPLE_WIDTH-1:0] s,
                                         logic [LOCK_WIDTH-1:0] lock);
      logic        locked, diff;
      int          slope, plen;
      logic [31:0] pmask;
      locked = (lock >= cfg.lock_threshold);
      // lock lost mid-frame: abort, still slice and track the sample
      if (!locked && dec_mode != MODE_ACQUIRE) begin
         dec_mode = MODE_ACQUIRE;
         push_decoded(KIND_ABORT, 8'd0, 1'b1);
         slice_hist  = {slice_hist[30:0], s > 0};
         prev_sample = s;
         return;
      end
      slice_hist = {slice_hist[30:0], s > 0};
      slope = int'(s) - int'(prev_sample);
      if (slope < 0) slope = -slope;
      prev_sample = s;
      case (dec_mode)
         MODE_ACQUIRE: begin
            if (locked && slope > int'(cfg.slope_threshold)) begin
               dec_mode   = MODE_HUNT;
               sample_cnt = '0;
               prev_level = 1'b0;
               bit_hist   = '0;
            end
         end
         MODE_HUNT: begin
            if (take_decision(diff)) begin
               bit_hist = {bit_hist[30:0], diff};
               plen  = (cfg.prefix_length > 32) ? 32 : int'(cfg.prefix_length);
               pmask = 32'((64'd1 << plen) - 64'd1);
               if (((bit_hist ^ cfg.prefix_pattern) & pmask) == 32'd0) begin
                  bit_idx  = '0;
                  byte_acc = '0;
                  dec_mode = MODE_SIZE;
               end
            end
         end
         default: begin
            if (take_decision(diff)) begin
               byte_acc = byte_acc | (8'(diff) << bit_idx);
               if (bit_idx != 3'd7) begin
                  bit_idx++;
               end else begin
                  bit_idx = '0;
                  if (dec_mode == MODE_SIZE) begin
                     bytes_left = byte_acc;
                     push_decoded(KIND_LENGTH, byte_acc, byte_acc == 8'd0);
                     if (byte_acc == 8'd0) dec_mode = MODE_ACQUIRE;
                     else dec_mode = MODE_COLLECT;
                  end else begin
                     bytes_left--;
                     push_decoded(KIND_DATA, byte_acc, bytes_left == 8'd0);
                     if (bytes_left == 8'd0) dec_mode = MODE_ACQUIRE;
                  end
                  byte_acc = '0;
               end
            end
         end
      endcase
   endfunction

   // register write into the model copy; unknown indexes fall through
   function automatic void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      case (idx)
         CSR_PREFIX_PATTERN:  cfg.prefix_pattern  = data;
         CSR_PREFIX_LENGTH:   cfg.prefix_length   = data[PLEN_WIDTH-1:0];
         CSR_BIT_PERIOD:      cfg.bit_period      = data[SPB_WIDTH-1:0];
         CSR_SLOPE_THRESHOLD: cfg.slope_threshold = data[SLOPE_WIDTH-1:0];
         CSR_LOCK_THRESHOLD:  cfg.lock_threshold  = data[LOCK_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void queue_sample(int s, int lock);
      sample_item_type item;
      item.in_phase   = SAMPLE_WIDTH'(s);
      item.lock_level = LOCK_WIDTH'(lock);
      sample_queue.push_back(item);
      issued_count++;
      gen_last = int'(item.in_phase);
   endfunction

   function automatic int locked_value();
      return int'($urandom_range(32767, cfg.lock_threshold));
   endfunction

   function automatic int unlocked_value();
      if (cfg.lock_threshold == 0) return 0;
      return int'($urandom_range(cfg.lock_threshold - 1, 0));
   endfunction

   // one bit period of samples, differentially coded, with rare noisy slices
   function automatic void queue_bit(logic diff);
      int   k, count;
      logic lvl;
      gen_level = gen_level ^ diff;
      count = (cfg.bit_period == 0) ? 1 : int'(cfg.bit_period);
      for (k = 0; k < count; k++) begin
         lvl = gen_level;
         if (count >= 4 && $urandom_range(15) == 0) lvl = ~lvl;
         if (lvl) queue_sample(int'($urandom_range(32767, 1)), locked_value());
         else queue_sample(-int'($urandom_range(32768, 0)), locked_value());
      end
   endfunction

   // kick, prefix, length byte and data bytes, optionally cut by lock loss
   function automatic void queue_frame(int len, logic do_abort);
      logic      frame_bits[$];
      int        plen, s, k, abort_at;
      logic [7:0] data;
      plen = (cfg.prefix_length > 32) ? 32 : int'(cfg.prefix_length);
      if ($urandom_range(1) == 1) queue_sample(int'($urandom_range(65535)), unlocked_value());
      s = (gen_last >= 0) ? -int'($urandom_range(32768, 28000))
                          : int'($urandom_range(32767, 28000));
      queue_sample(s, locked_value());
      gen_level = 1'b0;
      for (k = plen - 1; k >= 0; k--) frame_bits.push_back(cfg.prefix_pattern[k]);
      data = 8'(len);
      for (k = 0; k < 8; k++) frame_bits.push_back(data[k]);
      repeat (len) begin
         data = 8'($urandom);
         for (k = 0; k < 8; k++) frame_bits.push_back(data[k]);
      end
      abort_at = do_abort ? int'($urandom_range(frame_bits.size() - 1)) : -1;
      foreach (frame_bits[i]) begin
         if (i == abort_at) begin
            queue_sample(int'($urandom_range(65535)), unlocked_value());
            return;
         end
         queue_bit(frame_bits[i]);
      end
   endfunction

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(logic [31:0] pattern, int plen, int spb, int slope, int lock);
      write_csr(CSR_PREFIX_PATTERN, pattern);
      write_csr(CSR_PREFIX_LENGTH, 32'(plen));
      write_csr(CSR_BIT_PERIOD, 32'(spb));
      write_csr(CSR_SLOPE_THRESHOLD, 32'(slope));
      write_csr(CSR_LOCK_THRESHOLD, 32'(lock));
      @(negedge clock);
   endtask

   // sender pause: everything accepted, every result back, pipeline drained
   task automatic wait_idle();
      while (accepted_count != issued_count || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(int n_items, int max_len, logic quiet_phase, logic hold_phase);
      int first, len;
      quiet = quiet_phase;
      if (hold_phase) hold_arm = 1'b1;
      first = issued_count;
      while (issued_count - first < n_items) begin
         if (cfg.bit_period > 64 || $urandom_range(4) == 0) begin
            repeat ($urandom_range(8, 1))
               queue_sample(int'($urandom_range(65535)), int'($urandom_range(32767)));
         end else begin
            len = ($urandom_range(5) == 0) ? 0 : int'($urandom_range(max_len, 1));
            queue_frame(len, $urandom_range(6) == 0);
         end
      end
      wait_idle();
      quiet = 1'b0;
   endtask

   // main sequence
   initial begin
      cfg.prefix_pattern  = PREFIX_PATTERN_RESET;
      cfg.prefix_length   = PREFIX_LENGTH_RESET;
      cfg.bit_period      = BIT_PERIOD_RESET;
      cfg.slope_threshold = SLOPE_THRESHOLD_RESET;
      cfg.lock_threshold  = LOCK_THRESHOLD_RESET;
      slice_hist  = '0;
      prev_sample = '0;
      dec_mode    = MODE_ACQUIRE;
      sample_cnt  = '0;
      prev_level  = 1'b0;
      bit_hist    = '0;
      bit_idx     = '0;
      byte_acc    = '0;
      bytes_left  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: one-bit prefix, one sample per bit
      configure(32'h1, 1, 1, 0, 16384);
      queue_sample(-32768, 0);         // unlocked, most negative sample
      queue_sample(32767, 16383);      // just below lock threshold
      queue_sample(32767, 32767);      // locked, slope equal to threshold
      queue_sample(-1, 16384);         // lock exactly at threshold ends acquire
      queue_sample(1, 32767);          // prefix bit
      queue_sample(32767, 32767);      // zero length byte follows
      queue_sample(1, 16384);
      queue_sample(100, 30000);
      queue_sample(32767, 16384);
      queue_sample(2, 32767);
      queue_sample(5000, 20000);
      queue_sample(32767, 16384);
      queue_sample(1, 32767);
      queue_sample(-32768, 32767);     // kick for the next frame
      queue_sample(32767, 20000);      // prefix bit
      queue_sample(0, 20000);          // zero slices low
      queue_sample(-5, 20000);
      queue_sample(5, 100);            // lock loss mid length byte
      wait_idle();

      // directed: empty prefix, zero samples per bit, unknown register
      configure(32'h0, 0, 0, 100, 0);
      write_csr(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      @(negedge clock);
      queue_sample(-32768, 0);
      queue_sample(32767, 32767);
      queue_sample(12345, 1);
      queue_sample(-1, 0);
      queue_sample(0, 5);
      queue_sample(1, 32767);
      queue_sample(-32768, 0);
      queue_sample(32767, 77);
      queue_sample(7, 0);
      queue_sample(7, 9);
      wait_idle();

      // random frames under several settings
      configure(PREFIX_PATTERN_RESET, PREFIX_LENGTH_RESET, BIT_PERIOD_RESET,
                SLOPE_THRESHOLD_RESET, LOCK_THRESHOLD_RESET);
      run_random(150, 2, 1'b0, 1'b0);
      configure($urandom, 32, 2, 1000, 20000);
      run_random(100, 4, 1'b0, 1'b0);
      configure(32'hFFFF_FFFF, 63, 1, 0, 32767);
      run_random(100, 6, 1'b0, 1'b0);
      configure($urandom, 4, 33, int'($urandom_range(20000)), int'($urandom_range(30000, 1)));
      run_random(100, 1, 1'b0, 1'b0);
      // no idling and a long result stall
      configure($urandom, 8, 1, 500, 10000);
      run_random(200, 30, 1'b1, 1'b1);
      configure($urandom, 5, 65535, 65535, 0);
      run_random(40, 1, 1'b0, 1'b0);
      repeat (2) begin
         configure($urandom, int'($urandom_range(12, 1)), int'($urandom_range(5, 1)),
                   int'($urandom_range(30000)), int'($urandom_range(30000, 1)));
         run_random(150, 6, 1'b0, 1'b0);
      end

      if (error_count == 0 && decoded_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // long result back-pressure, counted here
   initial begin
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // sample driver
   always @(posedge clock) begin : sample_driver
      sample_item_type item;
      logic            fire;
      fire = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.in_phase   <= '0;
         req_if.lock_level <= '0;
      end else begin
         if (fire) begin
            decode_sample(req_if.in_phase, req_if.lock_level);
            accepted_count++;
         end
         if (!req_if.valid || fire) begin
            if (sample_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               item = sample_queue.pop_front();
               req_if.valid      <= 1'b1;
               req_if.in_phase   <= item.in_phase;
               req_if.lock_level <= item.lock_level;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : result_monitor
      decoded_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_queue.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected item: kind %0d value 0x%02h last %0d",
                           rsp_if.kind, rsp_if.value, rsp_if.last);
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_if.kind !== want.kind || rsp_if.value !== want.value ||
                   rsp_if.last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $write("mismatch: expected kind %0d value 0x%02h last %0d, ",
                            want.kind, want.value, want.last);
                     $display("got kind %0d value 0x%02h last %0d",
                              rsp_if.kind, rsp_if.value, rsp_if.last);
                  end
               end
            end
         end
         rsp_if.ready <= !rsp_hold && (quiet || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_TIME);
      $display("simulation failed");
      $finish;
   end

endmodule : tb_top
